// ===== hdl/sequence_pool_reduce_macros.svh =====
// Assertion macros for the checker file.
`ifndef SEQUENCE_POOL_REDUCE_MACROS_SVH
`define SEQUENCE_POOL_REDUCE_MACROS_SVH

// Check a property while reset is low.
`define SPR_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Check a property on every edge, reset included.
`define SPR_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

// ===== hdl/spr_pkg.sv =====
// Package of shared types and constants for the sequence pooling block.
package spr_pkg;

   localparam int MAX_FEATURES_DEF = 64;
   localparam int MAX_SEQ_ROWS_DEF = 65535;
   localparam int STORE_DEPTH      = 64;

   localparam int VALUE_W   = 16;
   localparam int POOLED_W  = 32;
   localparam int ROW_W     = 32;
   localparam int FEATURE_W = 6;
   localparam int ROWS_W    = 17;
   localparam int MODE_W    = 3;
   localparam int WIDTH_W   = 7;
   localparam int DIVIDEND_W = 40;
   localparam int DIVISOR_W  = 17;

   localparam logic [ROWS_W-1:0] ROWS_CAP = '1;

   localparam logic [MODE_W-1:0] MODE_MAX   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LAST  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIRST = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SUM   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_AVG   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SQRT  = 3'd5;

   localparam logic REG_POOL_MODE = 1'b0;
   localparam logic REG_ROW_WIDTH = 1'b1;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } spr_cmd_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_ROOT   = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_DONE   = 6'b100000
   } spr_state_type;

endpackage

// ===== hdl/spr_if.sv =====
// Channel interfaces for the input items and the result items.
interface spr_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [spr_pkg::VALUE_W-1:0] value;
   logic                               final_row;
   modport source (output valid, output value, output final_row, input ready);
   modport sink   (input valid, input value, input final_row, output ready);
endinterface

interface spr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [spr_pkg::POOLED_W-1:0] pooled;
   logic [spr_pkg::ROW_W-1:0]           max_row;
   logic [spr_pkg::FEATURE_W-1:0]       feature;
   logic                                last;
   logic                                too_long;
   modport source (output valid, output pooled, output max_row, output feature,
                   output last, output too_long, input ready);
   modport sink   (input valid, input pooled, input max_row, input feature,
                   input last, input too_long, output ready);
endinterface

// ===== hdl/spr_ram.sv =====
// Generic single write port RAM with registered read.
module spr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/spr_divsqrt.sv =====
// Shared shift-subtract unit: restoring divide or digit-by-digit square root.
module spr_divsqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  spr_pkg::spr_cmd_type                cmd,
   input  logic [spr_pkg::DIVIDEND_W-1:0]      operand,
   input  logic [spr_pkg::DIVISOR_W-1:0]       divisor,
   output logic                                done,
   output logic [spr_pkg::DIVIDEND_W-1:0]      result
);
   localparam int DW = spr_pkg::DIVIDEND_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          sqrt_ff, sqrt_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [19:0]   rem_ff, rem_in;
   logic [DW-1:0] src_ff, src_in;
   logic [DW-1:0] res_ff, res_in;
   logic [spr_pkg::DIVISOR_W-1:0] div_ff, div_in;
   logic [19:0]   shifted;
   logic [19:0]   trial;
   logic [20:0]   diff;
   logic          fits;

   always_comb begin
      shifted = sqrt_ff ? {rem_ff[17:0], src_ff[DW-1:DW-2]} : {rem_ff[18:0], src_ff[DW-1]};
      trial   = sqrt_ff ? {res_ff[17:0], 2'b01} : {3'b000, div_ff};
      diff    = {1'b0, shifted} - {1'b0, trial};
      fits    = !diff[20];

      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      src_in  = src_ff;
      res_in  = res_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         sqrt_in = cmd.is_sqrt;
         cnt_in  = cmd.is_sqrt ? 6'd17 : 6'(DW);
         rem_in  = '0;
         src_in  = operand;
         res_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[19:0] : shifted;
         res_in = {res_ff[DW-2:0], fits};
         src_in = sqrt_ff ? {src_ff[DW-3:0], 2'b00} : {src_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      res_ff  <= res_in;
      div_ff  <= div_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

// ===== hdl/sequence_pool_reduce.sv =====
// Top level of the sequence pooling block: sequencer, column store and CSRs.
// Use: feature elements arrive on req_bus (value, final_row) in row-major
// order, one item per handshake; row_width items make one row. Each item of
// a row flagged final_row gives one result item on rsp_bus carrying the
// pooled value, the row of the first maximum (max mode), the column, a last
// flag for the final column and too_long once the sequence passed
// MAX_SEQ_ROWS rows.
// Flow: each item is read from and written back to the column store in a
// read / update pair, and the next item is accepted only after that pair.
// On a final row the average mode divides on the shared shift-subtract
// unit; the square root mode first extracts a root and then divides by it.
// The unit gives one result bit per cycle.
// Configuration goes through the APB-style csr_ port (pool_mode at 0,
// row_width at 4); only write it while idle: the block does not enforce it.
// Reset clears the sequencer, the row counters and the registers; the
// column store is not cleared. When the receiver stalls, the result waits
// in the output register and the block takes further items until the next
// result needs that register, then holds there.
module sequence_pool_reduce #(
   parameter int MAX_FEATURES = spr_pkg::MAX_FEATURES_DEF,
   parameter int MAX_SEQ_ROWS = spr_pkg::MAX_SEQ_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   spr_req_if.sink     req_bus,
   spr_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int LIMIT = MAX_FEATURES < spr_pkg::STORE_DEPTH ? MAX_FEATURES
                                                              : spr_pkg::STORE_DEPTH;
   localparam int AW = LIMIT > 1 ? $clog2(LIMIT) : 1;
   localparam int FW = spr_pkg::FEATURE_W;
   localparam int RW = spr_pkg::ROWS_W;

   // configuration registers
   logic [spr_pkg::MODE_W-1:0]  pool_mode_ff, pool_mode_in;
   logic [spr_pkg::WIDTH_W-1:0] row_width_ff, row_width_in;
   logic                        csr_write;

   // sequence state
   spr_pkg::spr_state_type      state_ff, state_in;
   logic [FW-1:0]               feature_pos_ff, feature_pos_in;
   logic [RW-1:0]               seq_rows_ff, seq_rows_in;
   logic [spr_pkg::ROW_W-1:0]   global_row_ff, global_row_in;
   logic                        overflow_ff, overflow_in;

   // item held while it is worked on
   logic signed [spr_pkg::VALUE_W-1:0] val_ff, val_in;
   logic                        fin_ff, fin_in;
   logic [FW-1:0]               feat_ff, feat_in;
   logic [spr_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic                        first_ff, first_in;
   logic [RW-1:0]               n_ff, n_in;
   logic                        long_ff, long_in;
   logic                        rend_ff, rend_in;
   logic signed [31:0]          acc_ff, acc_in;
   logic [spr_pkg::ROW_W-1:0]   best_ff, best_in;
   logic                        neg_ff, neg_in;
   logic signed [31:0]          pool_ff, pool_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]          rsp_pooled_ff, rsp_pooled_in;
   logic [spr_pkg::ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [FW-1:0]               rsp_feat_ff, rsp_feat_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_long_ff, rsp_long_in;

   // column store and shared unit
   logic                        ram_we;
   logic [63:0]                 ram_wdata, ram_rdata;
   spr_pkg::spr_cmd_type        unit_cmd;
   logic [spr_pkg::DIVIDEND_W-1:0] unit_operand, unit_result;
   logic [spr_pkg::DIVISOR_W-1:0]  unit_divisor;
   logic                        unit_done;

   // accept-time decode
   logic                        accept;
   logic [FW-1:0]               f_cur;
   logic [spr_pkg::WIDTH_W-1:0] w_cur;
   logic [RW-1:0]               n_cur;

   // update-time values
   logic signed [31:0]          acc_old, acc_new;
   logic [spr_pkg::ROW_W-1:0]   best_old, best_new;
   logic signed [32:0]          sum_wide;
   logic [31:0]                 mag;
   logic [31:0]                 quot;
   logic                        out_free;

   spr_ram #(.WIDTH(64), .DEPTH(LIMIT)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (feat_ff[AW-1:0]),
      .wdata (ram_wdata),
      .raddr (feat_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   spr_divsqrt u_unit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (unit_cmd),
      .operand (unit_operand),
      .divisor (unit_divisor),
      .done    (unit_done),
      .result  (unit_result)
   );

   // CSR port: decode on the word address bit alone
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      pool_mode_in = pool_mode_ff;
      row_width_in = row_width_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            spr_pkg::REG_POOL_MODE: pool_mode_in = csr_pwdata[spr_pkg::MODE_W-1:0];
            spr_pkg::REG_ROW_WIDTH: row_width_in = csr_pwdata[spr_pkg::WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         spr_pkg::REG_POOL_MODE: csr_prdata = {29'd0, pool_mode_ff};
         spr_pkg::REG_ROW_WIDTH: csr_prdata = {25'd0, row_width_ff};
         default:                csr_prdata = '0;
      endcase
   end

   assign req_bus.ready = (state_ff == spr_pkg::ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // decode the item against the current column and row count
   always_comb begin
      f_cur = (32'(feature_pos_ff) >= LIMIT) ? '0 : feature_pos_ff;
      w_cur = (row_width_ff == '0) ? 7'd1 : row_width_ff;
      if (32'(w_cur) > LIMIT) begin
         w_cur = 7'(LIMIT);
      end
      n_cur = (seq_rows_ff == spr_pkg::ROWS_CAP) ? seq_rows_ff : seq_rows_ff + 1'b1;
   end

   // column update
   always_comb begin
      acc_old  = ram_rdata[31:0];
      best_old = ram_rdata[63:32];
      sum_wide = 33'(acc_old) + 33'(val_ff);
      acc_new  = acc_old;
      best_new = best_old;
      case (mode_ff)
         spr_pkg::MODE_MAX: begin
            if (first_ff || 32'(val_ff) > acc_old) begin
               acc_new  = 32'(val_ff);
               best_new = global_row_ff;
            end
         end
         spr_pkg::MODE_LAST: acc_new = 32'(val_ff);
         spr_pkg::MODE_FIRST: begin
            if (first_ff) begin
               acc_new = 32'(val_ff);
            end
         end
         default: begin
            if (first_ff) begin
               acc_new = 32'(val_ff);
            end else if (sum_wide[32] != sum_wide[31]) begin
               acc_new = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               acc_new = sum_wide[31:0];
            end
         end
      endcase
      mag  = acc_new[31] ? 32'(-acc_new) : 32'(acc_new);
      quot = unit_result[31:0];
   end

   assign ram_we    = (state_ff == spr_pkg::ST_UPDATE);
   assign ram_wdata = {best_new, acc_new};

   // sequencer
   always_comb begin
      state_in       = state_ff;
      feature_pos_in = feature_pos_ff;
      seq_rows_in    = seq_rows_ff;
      global_row_in  = global_row_ff;
      overflow_in    = overflow_ff;
      val_in   = val_ff;
      fin_in   = fin_ff;
      feat_in  = feat_ff;
      mode_in  = mode_ff;
      first_in = first_ff;
      n_in     = n_ff;
      long_in  = long_ff;
      rend_in  = rend_ff;
      acc_in   = acc_ff;
      best_in  = best_ff;
      neg_in   = neg_ff;
      pool_in  = pool_ff;
      unit_cmd     = '0;
      unit_operand = {8'd0, mag};
      unit_divisor = n_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_pooled_in = rsp_pooled_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_feat_in   = rsp_feat_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_long_in   = rsp_long_ff;

      case (state_ff)
         spr_pkg::ST_IDLE: begin
            if (accept) begin
               // latch the item and everything it needs from the counters
               val_in   = req_bus.value;
               fin_in   = req_bus.final_row;
               feat_in  = f_cur;
               mode_in  = (pool_mode_ff > spr_pkg::MODE_SQRT) ? spr_pkg::MODE_MAX
                                                              : pool_mode_ff;
               first_in = (seq_rows_ff == '0);
               n_in     = n_cur;
               long_in  = overflow_ff || (n_cur > RW'(MAX_SEQ_ROWS));
               rend_in  = (7'(f_cur) + 7'd1) >= w_cur;
               state_in = spr_pkg::ST_READ;
            end
         end
         spr_pkg::ST_READ: begin
            state_in = spr_pkg::ST_UPDATE;
         end
         spr_pkg::ST_UPDATE: begin
            acc_in  = acc_new;
            best_in = best_new;
            neg_in  = acc_new[31];
            pool_in = acc_new;
            // advance the column and row counters
            if (rend_ff) begin
               feature_pos_in = '0;
               global_row_in  = global_row_ff + 1'b1;
               if (fin_ff) begin
                  seq_rows_in = '0;
                  overflow_in = 1'b0;
               end else begin
                  if (seq_rows_ff != spr_pkg::ROWS_CAP) begin
                     seq_rows_in = seq_rows_ff + 1'b1;
                  end
                  if (seq_rows_in > RW'(MAX_SEQ_ROWS)) begin
                     overflow_in = 1'b1;
                  end
               end
            end else begin
               feature_pos_in = feat_ff + 1'b1;
            end
            if (!fin_ff) begin
               state_in = spr_pkg::ST_IDLE;
            end else if (mode_ff == spr_pkg::MODE_AVG) begin
               unit_cmd.start = 1'b1;
               state_in       = spr_pkg::ST_DIV;
            end else if (mode_ff == spr_pkg::MODE_SQRT) begin
               unit_cmd.start   = 1'b1;
               unit_cmd.is_sqrt = 1'b1;
               unit_operand     = {1'b0, n_ff, 22'd0};
               state_in         = spr_pkg::ST_ROOT;
            end else begin
               state_in = spr_pkg::ST_DONE;
            end
         end
         spr_pkg::ST_ROOT: begin
            // root ready: divide the scaled magnitude by it
            if (unit_done) begin
               unit_cmd.start = 1'b1;
               unit_operand   = {(acc_ff[31] ? 32'(-acc_ff) : 32'(acc_ff)), 8'd0};
               unit_divisor   = unit_result[spr_pkg::DIVISOR_W-1:0];
               state_in       = spr_pkg::ST_DIV;
            end
         end
         spr_pkg::ST_DIV: begin
            if (unit_done) begin
               pool_in  = neg_ff ? 32'(-quot) : 32'(quot);
               state_in = spr_pkg::ST_DONE;
            end
         end
         spr_pkg::ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pooled_in = pool_ff;
               rsp_row_in    = (mode_ff == spr_pkg::MODE_MAX) ? best_ff : '0;
               rsp_feat_in   = feat_ff;
               rsp_last_in   = rend_ff;
               rsp_long_in   = long_ff;
               state_in      = spr_pkg::ST_IDLE;
            end
         end
         default: state_in = spr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= spr_pkg::ST_IDLE;
         feature_pos_ff <= '0;
         seq_rows_ff    <= '0;
         global_row_ff  <= '0;
         overflow_ff    <= 1'b0;
         pool_mode_ff   <= spr_pkg::MODE_MAX;
         row_width_ff   <= 7'd1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         feature_pos_ff <= feature_pos_in;
         seq_rows_ff    <= seq_rows_in;
         global_row_ff  <= global_row_in;
         overflow_ff    <= overflow_in;
         pool_mode_ff   <= pool_mode_in;
         row_width_ff   <= row_width_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      val_ff   <= val_in;
      fin_ff   <= fin_in;
      feat_ff  <= feat_in;
      mode_ff  <= mode_in;
      first_ff <= first_in;
      n_ff     <= n_in;
      long_ff  <= long_in;
      rend_ff  <= rend_in;
      acc_ff   <= acc_in;
      best_ff  <= best_in;
      neg_ff   <= neg_in;
      pool_ff  <= pool_in;
      rsp_pooled_ff <= rsp_pooled_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_feat_ff   <= rsp_feat_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_long_ff   <= rsp_long_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.pooled   = rsp_pooled_ff;
   assign rsp_bus.max_row  = rsp_row_ff;
   assign rsp_bus.feature  = rsp_feat_ff;
   assign rsp_bus.last     = rsp_last_ff;
   assign rsp_bus.too_long = rsp_long_ff;
endmodule

// ===== hdl/spr_checker.sv =====
// Port-level checks for the sequence pooling block, bound to the top level.
`include "sequence_pool_reduce_macros.svh"

module spr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_pready
);
   // a waiting result stays offered
   `SPR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   // reset drops any pending result
   `SPR_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)
   // one item at a time: ready falls after an acceptance
   `SPR_ASSERT(a_one_item, clock, reset, req_valid && req_ready |=> !req_ready)
   // the register port never waits
   `SPR_ASSERT(a_pready, clock, reset, csr_pready)
endmodule

bind sequence_pool_reduce spr_checker u_spr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .csr_pready (csr_pready)
);
